/* hdl/header_table_fifo_eviction_defines.svh */
// Assertion macros shared by the header table checker.
// No dependencies; included by files that hold concurrent assertions.
`ifndef HEADER_TABLE_FIFO_EVICTION_DEFINES_SVH
`define HEADER_TABLE_FIFO_EVICTION_DEFINES_SVH

// Same-cycle implication, sampled on clk and switched off while rst_n is low.
`define HTFE_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("header table check failed");

// Next-cycle implication, sampled on clk and switched off while rst_n is low.
`define HTFE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("header table check failed");

`endif

/* hdl/htfe_pkg.sv */
// Shared constants, types and control structs of the header table.
// No dependencies; imported by every module of the block.
package htfe_pkg;

  localparam int CAPACITY        = 256;
  localparam int HANDLE_WIDTH    = 16;
  localparam int ENTRY_OVERHEAD  = 32;
  localparam int LIMIT_MAX       = CAPACITY * ENTRY_OVERHEAD;
  localparam int RESET_LIMIT_RAW = 4096;
  localparam int RESET_LIMIT     = (RESET_LIMIT_RAW < LIMIT_MAX) ? RESET_LIMIT_RAW : LIMIT_MAX;

  // Port field widths.
  localparam int OPCODE_W   = 2;
  localparam int F_HANDLE_W = 16;
  localparam int F_BYTES_W  = 16;
  localparam int INDEX_W    = 8;
  localparam int LIMIT_W    = 16;
  localparam int COUNT_O_W  = 9;
  localparam int TBYTES_O_W = 14;

  // Internal widths.
  localparam int SLOT_W  = $clog2(CAPACITY);
  localparam int CNT_W   = $clog2(CAPACITY + 1);
  localparam int BYTES_W = $clog2(LIMIT_MAX + 1);
  localparam int WRAP_W  = CNT_W + 1;
  localparam int BCMP_W  = (F_BYTES_W > BYTES_W) ? F_BYTES_W : BYTES_W;
  localparam int LCMP_W  = (LIMIT_W > BYTES_W) ? LIMIT_W : BYTES_W;
  localparam int ICMP_W  = (INDEX_W > CNT_W) ? INDEX_W : CNT_W;

  typedef logic [SLOT_W-1:0]       slot_t;
  typedef logic [CNT_W-1:0]        cnt_t;
  typedef logic [BYTES_W-1:0]      bytes_t;
  typedef logic [HANDLE_WIDTH-1:0] handle_t;
  typedef logic [WRAP_W-1:0]       wrap_t;

  typedef enum logic [OPCODE_W-1:0] {
    OP_ADD    = 2'd0,
    OP_GET    = 2'd1,
    OP_RESIZE = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic latch;
    logic set_limit;
    logic rd_get;
    logic rd_oldest;
    logic pop;
    logic insert;
    logic load_result;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_add;
    logic is_get;
    logic is_resize;
    logic drop;
    logic need_pop;
    logic out_free;
  } dp_status_t;

endpackage

/* hdl/header_table_fifo_eviction.sv */
// Channel   Direction  Handshake            Payload
// in_       request    in_valid/in_ready    opcode, handle, bytes, index, limit
// out_      result     out_valid/out_ready  hit, handle, bytes, dropped, count, bytes held
//
// A get passes through setup and the result before the next request can be taken.
// A resize adds a check, an add a check and an insertion, each plus a check and
// a pop per evicted entry: one read of the single-ported entry memory and one update.
// Reset (rst_n low, synchronous) empties the table and sets the limit to 4096
// bytes; the entry memory is not cleared, as only written slots are ever read.
// A result waits in the output register while out_ready is low; the next
// request is still taken and is processed up to the point of its result.
//
// Top level of the size-bounded header table with oldest-first eviction.
// Depends on htfe_pkg, htfe_ctrl and htfe_dp.
module header_table_fifo_eviction
  import htfe_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [OPCODE_W-1:0]   in_opcode,
  input  logic [F_HANDLE_W-1:0] in_entry_handle,
  input  logic [F_BYTES_W-1:0]  in_entry_bytes,
  input  logic [INDEX_W-1:0]    in_lookup_index,
  input  logic [LIMIT_W-1:0]    in_new_limit,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  out_hit,
  output logic [F_HANDLE_W-1:0] out_handle,
  output logic [F_BYTES_W-1:0]  out_bytes,
  output logic                  out_dropped,
  output logic [COUNT_O_W-1:0]  out_entry_count,
  output logic [TBYTES_O_W-1:0] out_table_bytes
);

  // The controller steps through setup, the eviction loop, insertion and the
  // result; the datapath holds the table and answers with status flags.
  dp_cmd_t    cmd;
  dp_status_t status;

  htfe_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // The eviction loop runs while the table holds more bytes than the target
  // (limit minus the new entry for an add, the new limit for a resize, zero
  // for an oversized add), or while every slot is taken by a pending add.
  htfe_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_opcode       (in_opcode),
    .in_entry_handle (in_entry_handle),
    .in_entry_bytes  (in_entry_bytes),
    .in_lookup_index (in_lookup_index),
    .in_new_limit    (in_new_limit),
    .cmd             (cmd),
    .status          (status),
    .out_ready       (out_ready),
    .out_valid       (out_valid),
    .out_hit         (out_hit),
    .out_handle      (out_handle),
    .out_bytes       (out_bytes),
    .out_dropped     (out_dropped),
    .out_entry_count (out_entry_count),
    .out_table_bytes (out_table_bytes)
  );

endmodule

/* hdl/htfe_dp.sv */
// Datapath of the header table: entry memory, counters, eviction arithmetic
// and the result register. Depends on htfe_pkg.
module htfe_dp
  import htfe_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [OPCODE_W-1:0]   in_opcode,
  input  logic [F_HANDLE_W-1:0] in_entry_handle,
  input  logic [F_BYTES_W-1:0]  in_entry_bytes,
  input  logic [INDEX_W-1:0]    in_lookup_index,
  input  logic [LIMIT_W-1:0]    in_new_limit,
  input  dp_cmd_t               cmd,
  output dp_status_t            status,
  input  logic                  out_ready,
  output logic                  out_valid,
  output logic                  out_hit,
  output logic [F_HANDLE_W-1:0] out_handle,
  output logic [F_BYTES_W-1:0]  out_bytes,
  output logic                  out_dropped,
  output logic [COUNT_O_W-1:0]  out_entry_count,
  output logic [TBYTES_O_W-1:0] out_table_bytes
);

  // Latched request.
  op_t                   op_r;
  handle_t               handle_r;
  logic [F_BYTES_W-1:0]  ebytes_r;
  logic [INDEX_W-1:0]    idx_r;
  logic [LIMIT_W-1:0]    newlim_r;

  // Table state.
  slot_t  newest_r, newest_nxt;
  cnt_t   count_r, count_nxt;
  bytes_t bytes_r, bytes_nxt;
  bytes_t limit_r, limit_nxt;

  // Entry storage, undefined until written.
  handle_t mem_handle [CAPACITY];
  bytes_t  mem_bytes  [CAPACITY];
  handle_t rd_handle_r;
  bytes_t  rd_bytes_r;

  // Result register.
  logic                  out_valid_r;
  logic                  out_hit_r;
  logic [F_HANDLE_W-1:0] out_handle_r;
  logic [F_BYTES_W-1:0]  out_bytes_r;
  logic                  out_dropped_r;
  logic [COUNT_O_W-1:0]  out_count_r;
  logic [TBYTES_O_W-1:0] out_tbytes_r;

  logic   drop;
  bytes_t target;
  logic   full;
  logic   need_pop;
  logic   hit;
  bytes_t sat_limit;
  wrap_t  oldest_w, get_w;
  slot_t  oldest_slot, get_slot, newest_inc, ins_slot, rd_addr;

  always_comb begin
    drop      = BCMP_W'(ebytes_r) > BCMP_W'(limit_r);
    if (op_r == OP_ADD) begin
      target = drop ? '0 : bytes_t'(limit_r - BYTES_W'(ebytes_r));
    end else begin
      target = limit_r;
    end
    full      = count_r == CNT_W'(CAPACITY);
    need_pop  = (count_r != '0) &&
                ((bytes_r > target) || ((op_r == OP_ADD) && !drop && full));
    hit       = ICMP_W'(idx_r) < ICMP_W'(count_r);
    sat_limit = (LCMP_W'(newlim_r) > LCMP_W'(LIMIT_MAX)) ? BYTES_W'(LIMIT_MAX)
                                                          : BYTES_W'(newlim_r);

    // Oldest entry sits count-1 slots behind the newest one, modulo the capacity.
    oldest_w = WRAP_W'(newest_r) + WRAP_W'(CAPACITY + 1) - WRAP_W'(count_r);
    if (oldest_w >= WRAP_W'(CAPACITY)) begin
      oldest_w = oldest_w - WRAP_W'(CAPACITY);
    end
    oldest_slot = oldest_w[SLOT_W-1:0];

    get_w = WRAP_W'(newest_r) + WRAP_W'(CAPACITY) - WRAP_W'(idx_r);
    if (get_w >= WRAP_W'(CAPACITY)) begin
      get_w = get_w - WRAP_W'(CAPACITY);
    end
    get_slot = get_w[SLOT_W-1:0];

    newest_inc = (newest_r == SLOT_W'(CAPACITY - 1)) ? '0 : slot_t'(newest_r + 1'b1);
    ins_slot   = (count_r != '0) ? newest_inc : newest_r;
    rd_addr    = cmd.rd_get ? get_slot : oldest_slot;
  end

  always_comb begin
    newest_nxt = newest_r;
    count_nxt  = count_r;
    bytes_nxt  = bytes_r;
    limit_nxt  = limit_r;
    if (cmd.pop) begin
      count_nxt = count_r - 1'b1;
      bytes_nxt = bytes_r - rd_bytes_r;
    end
    if (cmd.insert) begin
      newest_nxt = ins_slot;
      count_nxt  = count_r + 1'b1;
      bytes_nxt  = bytes_r + BYTES_W'(ebytes_r);
    end
    if (cmd.set_limit) begin
      limit_nxt = sat_limit;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      newest_r <= '0;
      count_r  <= '0;
      bytes_r  <= '0;
      limit_r  <= BYTES_W'(RESET_LIMIT);
    end else begin
      newest_r <= newest_nxt;
      count_r  <= count_nxt;
      bytes_r  <= bytes_nxt;
      limit_r  <= limit_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_r     <= op_t'(in_opcode);
      handle_r <= HANDLE_WIDTH'(in_entry_handle);
      ebytes_r <= in_entry_bytes;
      idx_r    <= in_lookup_index;
      newlim_r <= in_new_limit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.insert) begin
      mem_handle[ins_slot] <= handle_r;
      mem_bytes[ins_slot]  <= BYTES_W'(ebytes_r);
    end
    if (cmd.rd_get || cmd.rd_oldest) begin
      rd_handle_r <= mem_handle[rd_addr];
      rd_bytes_r  <= mem_bytes[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_result) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_result) begin
      out_hit_r     <= (op_r == OP_GET) && hit;
      out_handle_r  <= ((op_r == OP_GET) && hit) ? F_HANDLE_W'(rd_handle_r) : '0;
      out_bytes_r   <= ((op_r == OP_GET) && hit) ? F_BYTES_W'(rd_bytes_r) : '0;
      out_dropped_r <= (op_r == OP_ADD) && drop;
      out_count_r   <= COUNT_O_W'(count_r);
      out_tbytes_r  <= TBYTES_O_W'(bytes_r);
    end
  end

  assign status.is_add    = op_r == OP_ADD;
  assign status.is_get    = op_r == OP_GET;
  assign status.is_resize = op_r == OP_RESIZE;
  assign status.drop      = drop;
  assign status.need_pop  = need_pop;
  assign status.out_free  = !out_valid_r || out_ready;

  assign out_valid       = out_valid_r;
  assign out_hit         = out_hit_r;
  assign out_handle      = out_handle_r;
  assign out_bytes       = out_bytes_r;
  assign out_dropped     = out_dropped_r;
  assign out_entry_count = out_count_r;
  assign out_table_bytes = out_tbytes_r;

endmodule

/* hdl/htfe_ctrl.sv */
// Controller of the header table: sequences one request through setup,
// eviction, insertion and result. Depends on htfe_pkg.
module htfe_ctrl
  import htfe_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_CHECK,
    ST_POP,
    ST_INSERT,
    ST_RESULT
  } state_t;

  state_t state_r;
  logic   in_ready_r;

  always_comb begin
    cmd = '0;
    case (state_r)
      ST_IDLE: begin
        cmd.latch = in_valid && in_ready_r;
      end
      ST_SETUP: begin
        cmd.set_limit = status.is_resize;
        cmd.rd_get    = status.is_get;
      end
      ST_CHECK: begin
        cmd.rd_oldest = status.need_pop;
      end
      ST_POP: begin
        cmd.pop = 1'b1;
      end
      ST_INSERT: begin
        cmd.insert = 1'b1;
      end
      ST_RESULT: begin
        cmd.load_result = status.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      in_ready_r <= 1'b1;
    end else begin
      case (state_r)
        ST_IDLE: begin
          if (in_valid && in_ready_r) begin
            state_r    <= ST_SETUP;
            in_ready_r <= 1'b0;
          end
        end
        ST_SETUP: begin
          if (status.is_add || status.is_resize) begin
            state_r <= ST_CHECK;
          end else begin
            state_r <= ST_RESULT;
          end
        end
        ST_CHECK: begin
          if (status.need_pop) begin
            state_r <= ST_POP;
          end else if (status.is_add && !status.drop) begin
            state_r <= ST_INSERT;
          end else begin
            state_r <= ST_RESULT;
          end
        end
        ST_POP: begin
          state_r <= ST_CHECK;
        end
        ST_INSERT: begin
          state_r <= ST_RESULT;
        end
        ST_RESULT: begin
          if (status.out_free) begin
            state_r    <= ST_IDLE;
            in_ready_r <= 1'b1;
          end
        end
        default: begin
          state_r    <= ST_IDLE;
          in_ready_r <= 1'b1;
        end
      endcase
    end
  end

  assign in_ready = in_ready_r;

endmodule

/* hdl/htfe_checker.sv */
// Port-level checker for the header table, bound to the top level.
// Depends on htfe_pkg and header_table_fifo_eviction_defines.svh.
`include "header_table_fifo_eviction_defines.svh"

module htfe_checker
  import htfe_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_valid,
  input logic                  in_ready,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic                  out_hit,
  input logic [F_HANDLE_W-1:0] out_handle,
  input logic [F_BYTES_W-1:0]  out_bytes,
  input logic                  out_dropped,
  input logic [TBYTES_O_W-1:0] out_table_bytes
);

  // A stalled result keeps its payload.
  `HTFE_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_handle) && $stable(out_table_bytes))

  // A miss, or any non-get request, reports an empty entry.
  `HTFE_ASSERT_IMPL(a_miss_zero, out_valid && !out_hit, out_handle == '0 && out_bytes == '0)

  // A dropped add leaves no bytes held; zero-byte entries may still remain.
  `HTFE_ASSERT_IMPL(a_drop_empty, out_valid && out_dropped, out_table_bytes == '0 && !out_hit)

  // Requests are worked one at a time: no request is taken right after another.
  `HTFE_ASSERT_NEXT(a_one_at_a_time, in_valid && in_ready, !in_ready)

endmodule

bind header_table_fifo_eviction htfe_checker u_htfe_checker (.*);
